// File: rtl/core/triangle_angle_classifier_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef TRIANGLE_ANGLE_CLASSIFIER_ASSERT_SVH
`define TRIANGLE_ANGLE_CLASSIFIER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TAC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/core/tac_pkg.sv
package tac_pkg;

    localparam int CoordBits   = 12;
    localparam int FracBits    = 8;
    localparam int AngFrac     = 16;
    localparam int Preshift    = 20;
    localparam int CordicSteps = 20;

    localparam int InW   = 12;
    localparam int OutW  = 16;
    localparam int AreaW = 24;
    localparam logic [AreaW-1:0] MinAreaReset = AreaW'(100);

    localparam int UseW  = (CoordBits < InW) ? CoordBits : InW;
    localparam int DiffW = CoordBits + 1;
    localparam int SqW   = 2 * CoordBits;
    localparam int ProdW = 2 * CoordBits + 1;
    localparam int SumW  = SqW + 1;
    localparam int CrW   = 2 * CoordBits + 2;
    localparam int AbsW  = 2 * CoordBits + 1;
    localparam int NW    = 2 * CoordBits + 3;
    localparam int XW    = 2 * CoordBits + Preshift + 6;
    localparam int ZW    = 26;
    localparam int CmpW  = (AbsW > AreaW + 1) ? AbsW : AreaW + 1;

    localparam int FrontStages = 4;
    localparam int NStages     = FrontStages + CordicSteps + 1;

    localparam logic signed [ZW-1:0] RightZ = ZW'(90 << AngFrac);
    localparam logic signed [ZW-1:0] FlatZ  = ZW'(180 << AngFrac);
    localparam int RoundSh  = AngFrac - FracBits;
    localparam int RoundAdd = (RoundSh > 0) ? (1 << (RoundSh - 1)) : 0;
    localparam logic [OutW-1:0] RightOut = OutW'(90 << FracBits);
    localparam logic [OutW-1:0] FlatOut  = OutW'(180 << FracBits);

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 neg;
        logic                 nzero;
        logic                 szero;
    } t_cordic;

    typedef struct packed {
        logic degen;
        logic big;
        logic right;
    } t_side;

    function automatic logic signed [ZW-1:0] atan_entry(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/tac_tri_if.sv
interface tac_tri_if;
    logic                     valid;
    logic                     ready;
    logic [tac_pkg::InW-1:0]  x0;
    logic [tac_pkg::InW-1:0]  y0;
    logic [tac_pkg::InW-1:0]  x1;
    logic [tac_pkg::InW-1:0]  y1;
    logic [tac_pkg::InW-1:0]  x2;
    logic [tac_pkg::InW-1:0]  y2;

    modport source (output valid, output x0, output y0, output x1, output y1,
                    output x2, output y2, input ready);
    modport sink (input valid, input x0, input y0, input x1, input y1,
                  input x2, input y2, output ready);
endinterface

// File: rtl/core/tac_ang_if.sv
interface tac_ang_if;
    logic                     valid;
    logic                     ready;
    logic [tac_pkg::OutW-1:0] angle_first;
    logic [tac_pkg::OutW-1:0] angle_second;
    logic [tac_pkg::OutW-1:0] angle_third;
    logic                     right_angle;
    logic                     big_enough;
    logic                     degenerate;

    modport source (output valid, output angle_first, output angle_second,
                    output angle_third, output right_angle, output big_enough,
                    output degenerate, input ready);
    modport sink (input valid, input angle_first, input angle_second,
                  input angle_third, input right_angle, input big_enough,
                  input degenerate, output ready);
endinterface

// File: rtl/core/tac_cordic.sv
module tac_cordic (
    input  logic                                i_clk,
    input  logic [tac_pkg::CordicSteps-1:0]     i_en,
    input  tac_pkg::t_cordic                    i_init,
    output tac_pkg::t_cordic                    o_res
);

    tac_pkg::t_cordic r_st [tac_pkg::CordicSteps];

    genvar g;
    generate
        for (g = 0; g < tac_pkg::CordicSteps; g++) begin : g_step
            tac_pkg::t_cordic prev;
            tac_pkg::t_cordic n_st;
            if (g == 0) begin : g_first
                assign prev = i_init;
            end else begin : g_rest
                assign prev = r_st[g-1];
            end
            always_comb begin
                n_st = prev;
                if (!prev.y[tac_pkg::XW-1]) begin
                    n_st.x = prev.x + (prev.y >>> g);
                    n_st.y = prev.y - (prev.x >>> g);
                    n_st.z = prev.z + tac_pkg::atan_entry(g);
                end else begin
                    n_st.x = prev.x - (prev.y >>> g);
                    n_st.y = prev.y + (prev.x >>> g);
                    n_st.z = prev.z - tac_pkg::atan_entry(g);
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en[g]) begin
                    r_st[g] <= n_st;
                end
            end
        end
    endgenerate

    assign o_res = r_st[tac_pkg::CordicSteps-1];

endmodule

// File: rtl/core/triangle_angle_classifier.sv
// Triangle angle classifier: one triangle transaction is accepted per clock while the
// pipeline is not stalled, and its result passes through 25 register stages (four geometry
// stages, a 20-stage CORDIC per vertex, one output stage). Throughput is one triangle per
// cycle; a stall on the output holds the pipeline and bubbles close up, so no transaction
// is lost or repeated. The min_area register resets to 100 and should be written only
// while the pipeline is empty.
module triangle_angle_classifier (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tac_pkg::AreaW-1:0] i_cfg_data,
    tac_tri_if.sink                   i_tri,
    tac_ang_if.source                 o_ang
);

    localparam int NS = tac_pkg::NStages;
    localparam int FS = tac_pkg::FrontStages;

    function automatic logic signed [tac_pkg::DiffW-1:0] coord_diff(
        input logic [tac_pkg::InW-1:0] a, input logic [tac_pkg::InW-1:0] b);
        logic [tac_pkg::CoordBits-1:0] ca;
        logic [tac_pkg::CoordBits-1:0] cb;
        ca = tac_pkg::CoordBits'(a[tac_pkg::UseW-1:0]);
        cb = tac_pkg::CoordBits'(b[tac_pkg::UseW-1:0]);
        return tac_pkg::DiffW'(cb) - tac_pkg::DiffW'(ca);
    endfunction

    function automatic logic [tac_pkg::OutW-1:0] angle_out(input tac_pkg::t_cordic c,
                                                             input logic degen);
        logic signed [tac_pkg::ZW-1:0] zc;
        logic signed [tac_pkg::ZW-1:0] zf;
        logic [tac_pkg::ZW:0]          zr;
        zc = c.z;
        if (zc < 0) begin
            zc = '0;
        end
        if (zc > tac_pkg::RightZ) begin
            zc = tac_pkg::RightZ;
        end
        zf = c.neg ? tac_pkg::FlatZ - zc : zc;
        if (c.nzero) begin
            zf = tac_pkg::RightZ;
        end else if (c.szero) begin
            zf = c.neg ? tac_pkg::FlatZ : '0;
        end
        zr = ((tac_pkg::ZW + 1)'(unsigned'(zf)) + (tac_pkg::ZW + 1)'(tac_pkg::RoundAdd))
             >> tac_pkg::RoundSh;
        return degen ? '0 : zr[tac_pkg::OutW-1:0];
    endfunction

    logic [tac_pkg::AreaW-1:0] r_min_area;
    logic [NS-1:0]             r_valid;
    logic [NS:0]               en;

    logic signed [tac_pkg::DiffW-1:0] r_dx01, r_dy01, r_dx02, r_dy02, r_dx12, r_dy12;
    logic [tac_pkg::SqW-1:0]          r_q01x, r_q01y, r_q02x, r_q02y, r_q12x, r_q12y;
    logic signed [tac_pkg::ProdW-1:0] r_pa, r_pb;
    logic [tac_pkg::SumW-1:0]         r_s01, r_s02, r_s12;
    logic [tac_pkg::AbsW-1:0]         r_cr;

    logic signed [tac_pkg::CrW-1:0]   cr_full;
    logic [tac_pkg::CrW-1:0]          cr_abs;
    logic signed [tac_pkg::NW-1:0]    n_num [3];
    logic [tac_pkg::NW-1:0]           n_abs [3];
    tac_pkg::t_cordic                 n_lane [3];
    tac_pkg::t_cordic                 r_lane [3];
    tac_pkg::t_cordic                 res [3];
    tac_pkg::t_side                   n_side;
    tac_pkg::t_side                   r_side [FS-1:NS-2];

    logic [tac_pkg::OutW-1:0]         r_ang [3];
    logic                             r_right, r_big, r_degen;

    assign en[NS] = o_ang.ready;
    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_en
            assign en[k] = !r_valid[k] || en[k+1];
        end
    endgenerate

    assign i_tri.ready = en[0];
    assign o_ang.valid = r_valid[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_area <= tac_pkg::MinAreaReset;
            r_valid    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_min_area <= i_cfg_data;
            end
            if (en[0]) begin
                r_valid[0] <= i_tri.valid;
            end
            for (int i = 1; i < NS; i++) begin
                if (en[i]) begin
                    r_valid[i] <= r_valid[i-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx01 <= coord_diff(i_tri.x0, i_tri.x1);
            r_dy01 <= coord_diff(i_tri.y0, i_tri.y1);
            r_dx02 <= coord_diff(i_tri.x0, i_tri.x2);
            r_dy02 <= coord_diff(i_tri.y0, i_tri.y2);
            r_dx12 <= coord_diff(i_tri.x1, i_tri.x2);
            r_dy12 <= coord_diff(i_tri.y1, i_tri.y2);
        end
        if (en[1]) begin
            r_q01x <= tac_pkg::SqW'(r_dx01) * tac_pkg::SqW'(r_dx01);
            r_q01y <= tac_pkg::SqW'(r_dy01) * tac_pkg::SqW'(r_dy01);
            r_q02x <= tac_pkg::SqW'(r_dx02) * tac_pkg::SqW'(r_dx02);
            r_q02y <= tac_pkg::SqW'(r_dy02) * tac_pkg::SqW'(r_dy02);
            r_q12x <= tac_pkg::SqW'(r_dx12) * tac_pkg::SqW'(r_dx12);
            r_q12y <= tac_pkg::SqW'(r_dy12) * tac_pkg::SqW'(r_dy12);
            r_pa   <= tac_pkg::ProdW'(r_dx01) * tac_pkg::ProdW'(r_dy02);
            r_pb   <= tac_pkg::ProdW'(r_dy01) * tac_pkg::ProdW'(r_dx02);
        end
        if (en[2]) begin
            r_s01 <= tac_pkg::SumW'(r_q01x) + tac_pkg::SumW'(r_q01y);
            r_s02 <= tac_pkg::SumW'(r_q02x) + tac_pkg::SumW'(r_q02y);
            r_s12 <= tac_pkg::SumW'(r_q12x) + tac_pkg::SumW'(r_q12y);
            r_cr  <= cr_abs[tac_pkg::AbsW-1:0];
        end
    end

    always_comb begin
        cr_full = tac_pkg::CrW'(r_pa) - tac_pkg::CrW'(r_pb);
        cr_abs  = cr_full[tac_pkg::CrW-1] ? unsigned'(-cr_full) : unsigned'(cr_full);
    end

    always_comb begin
        n_num[0] = tac_pkg::NW'(r_s01) + tac_pkg::NW'(r_s02) - tac_pkg::NW'(r_s12);
        n_num[1] = tac_pkg::NW'(r_s01) + tac_pkg::NW'(r_s12) - tac_pkg::NW'(r_s02);
        n_num[2] = tac_pkg::NW'(r_s02) + tac_pkg::NW'(r_s12) - tac_pkg::NW'(r_s01);
        for (int i = 0; i < 3; i++) begin
            n_abs[i]        = n_num[i][tac_pkg::NW-1] ? unsigned'(-n_num[i])
                                                      : unsigned'(n_num[i]);
            n_lane[i].x     = signed'(tac_pkg::XW'(n_abs[i]) << tac_pkg::Preshift);
            n_lane[i].y     = signed'(tac_pkg::XW'({r_cr, 1'b0}) << tac_pkg::Preshift);
            n_lane[i].z     = '0;
            n_lane[i].neg   = n_num[i][tac_pkg::NW-1];
            n_lane[i].nzero = (n_num[i] == '0);
            n_lane[i].szero = (r_cr == '0);
        end
        n_side.degen = (r_s01 == '0) || (r_s02 == '0) || (r_s12 == '0);
        n_side.big   = tac_pkg::CmpW'(r_cr) > (tac_pkg::CmpW'(r_min_area) << 1);
        n_side.right = !n_side.degen
                       && (n_lane[0].nzero || n_lane[1].nzero || n_lane[2].nzero);
    end

    always_ff @(posedge i_clk) begin
        if (en[FS-1]) begin
            r_lane         <= n_lane;
            r_side[FS-1]   <= n_side;
        end
        for (int i = FS; i <= NS - 2; i++) begin
            if (en[i]) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    generate
        for (k = 0; k < 3; k++) begin : g_lane
            tac_cordic u_cordic (
                .i_clk  (i_clk),
                .i_en   (en[FS +: tac_pkg::CordicSteps]),
                .i_init (r_lane[k]),
                .o_res  (res[k])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (en[NS-1]) begin
            for (int i = 0; i < 3; i++) begin
                r_ang[i] <= angle_out(res[i], r_side[NS-2].degen);
            end
            r_right <= r_side[NS-2].right;
            r_big   <= r_side[NS-2].big;
            r_degen <= r_side[NS-2].degen;
        end
    end

    assign o_ang.angle_first  = r_ang[0];
    assign o_ang.angle_second = r_ang[1];
    assign o_ang.angle_third  = r_ang[2];
    assign o_ang.right_angle  = r_right;
    assign o_ang.big_enough   = r_big;
    assign o_ang.degenerate   = r_degen;

endmodule

// File: rtl/core/tac_checker.sv
`include "triangle_angle_classifier_assert.svh"

module tac_checker (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_ready,
    input logic                     i_out_valid,
    input logic                     i_out_ready,
    input logic [tac_pkg::OutW-1:0] i_angle_first,
    input logic [tac_pkg::OutW-1:0] i_angle_second,
    input logic [tac_pkg::OutW-1:0] i_angle_third,
    input logic                     i_right_angle,
    input logic                     i_degenerate
);

    `TAC_ASSERT_IMPL(a_degen_zero, i_clk, i_rst_n, i_out_valid && i_degenerate, i_angle_first == '0 && i_angle_second == '0 && i_angle_third == '0 && !i_right_angle)
    `TAC_ASSERT_IMPL(a_angle_range, i_clk, i_rst_n, i_out_valid, i_angle_first <= tac_pkg::FlatOut && i_angle_second <= tac_pkg::FlatOut && i_angle_third <= tac_pkg::FlatOut)
    `TAC_ASSERT_IMPL(a_right_ninety, i_clk, i_rst_n, i_out_valid && i_right_angle, i_angle_first == tac_pkg::RightOut || i_angle_second == tac_pkg::RightOut || i_angle_third == tac_pkg::RightOut)
    `TAC_ASSERT_IMPL(a_ready_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)
    `TAC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_angle_first))

endmodule

bind triangle_angle_classifier tac_checker u_tac_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_tri.ready),
    .i_out_valid    (o_ang.valid),
    .i_out_ready    (o_ang.ready),
    .i_angle_first  (o_ang.angle_first),
    .i_angle_second (o_ang.angle_second),
    .i_angle_third  (o_ang.angle_third),
    .i_right_angle  (o_ang.right_angle),
    .i_degenerate   (o_ang.degenerate)
);
